@@ rtl/core/fqd_pkg.sv @@
// ============================================================================
// fqd_pkg : shared types and constants for the handle queue
// Queue depth, derived widths, command codes, controller states and the
// command bundle from the controller to the datapath.
// ============================================================================
package fqd_pkg;

    localparam int DEPTH  = 16;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int LEN_W  = 5;

    typedef enum logic [1:0] {
        CMD_ENQ = 2'd0,
        CMD_DEQ = 2'd1,
        CMD_DEL = 2'd2,
        CMD_LEN = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    typedef struct packed {
        logic capture;
        logic execute;
    } ctrl_t;

endpackage

@@ rtl/core/fqd_ctrl.sv @@
// ============================================================================
// fqd_ctrl : queue controller
// Two-state sequencer: capture a command, then execute it once the result
// register is free. Owns the result valid flag.
// ============================================================================
module fqd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output fqd_pkg::ctrl_t ctrl
);

    fqd_pkg::state_t state_reg;
    fqd_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_comb
    begin
        state_next   = state_reg;
        ctrl.capture = 1'b0;
        ctrl.execute = 1'b0;
        unique case (state_reg)
            fqd_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    ctrl.capture = 1'b1;
                    state_next   = fqd_pkg::ST_EXEC;
                end
            end
            fqd_pkg::ST_EXEC:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    ctrl.execute = 1'b1;
                    state_next   = fqd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fqd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        priority if (ctrl.execute)
            out_valid_next = 1'b1;
        else if (rsp_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fqd_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign cmd_ready = (state_reg == fqd_pkg::ST_IDLE);
    assign rsp_valid = out_valid_reg;

endmodule

@@ rtl/core/fqd_datapath.sv @@
// ============================================================================
// fqd_datapath : entry chain, count and result registers
// Entries sit in order with the head in slot 0. A removal compacts the
// chain in one step by shifting every slot at or after the hit position.
// ============================================================================
module fqd_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fqd_pkg::ctrl_t               ctrl,
    input  logic [1:0]                   cmd,
    input  logic [fqd_pkg::DATA_W-1:0]   value,
    output logic                         status,
    output logic [fqd_pkg::DATA_W-1:0]   data_out,
    output logic [fqd_pkg::LEN_W-1:0]    length
);

    fqd_pkg::cmd_t                    cmd_reg;
    logic [fqd_pkg::DATA_W-1:0]       value_reg;
    logic [fqd_pkg::DATA_W-1:0]       entries_reg [fqd_pkg::DEPTH];
    logic [fqd_pkg::DATA_W-1:0]       entries_next [fqd_pkg::DEPTH];
    logic [fqd_pkg::CNT_W-1:0]        count_reg;
    logic [fqd_pkg::CNT_W-1:0]        count_next;
    logic                             status_next;
    logic [fqd_pkg::DATA_W-1:0]       data_next;
    logic                             status_reg;
    logic [fqd_pkg::DATA_W-1:0]       data_reg;
    logic [fqd_pkg::LEN_W-1:0]        length_reg;

    logic [fqd_pkg::DEPTH-1:0]        match;
    logic [fqd_pkg::DEPTH-1:0]        hit_mask;
    logic [fqd_pkg::DEPTH-1:0]        shift_mask;
    logic                             hit_any;
    logic                             value_nz;
    logic                             do_enq;
    logic                             do_remove;

    always_comb
    begin
        hit_any = 1'b0;
        for (int i = 0; i < fqd_pkg::DEPTH; i++)
        begin
            match[i]    = (entries_reg[i] == value_reg) &&
                          (fqd_pkg::CNT_W'(i) < count_reg);
            hit_any     = hit_any | match[i];
            hit_mask[i] = hit_any;
        end
    end

    assign value_nz = (value_reg != '0);

    always_comb
    begin
        status_next = 1'b0;
        data_next   = '0;
        do_enq      = 1'b0;
        do_remove   = 1'b0;
        shift_mask  = '1;
        unique case (cmd_reg)
            fqd_pkg::CMD_ENQ:
            begin
                do_enq      = value_nz && (count_reg < fqd_pkg::CNT_W'(fqd_pkg::DEPTH));
                status_next = !do_enq;
            end
            fqd_pkg::CMD_DEQ:
            begin
                do_remove   = (count_reg != '0);
                status_next = !do_remove;
                data_next   = do_remove ? entries_reg[0] : '0;
            end
            fqd_pkg::CMD_DEL:
            begin
                do_remove   = value_nz && hit_any;
                status_next = !do_remove;
                shift_mask  = hit_mask;
            end
            fqd_pkg::CMD_LEN:
            begin
                status_next = 1'b0;
            end
            default:
            begin
                status_next = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < fqd_pkg::DEPTH; i++)
        begin
            entries_next[i] = entries_reg[i];
            if (do_enq && (count_reg == fqd_pkg::CNT_W'(i)))
                entries_next[i] = value_reg;
            if (do_remove && shift_mask[i] && (i < fqd_pkg::DEPTH - 1))
                entries_next[i] = entries_reg[(i + 1) % fqd_pkg::DEPTH];
        end
        priority if (do_enq)
            count_next = count_reg + 1'b1;
        else if (do_remove)
            count_next = count_reg - 1'b1;
        else
            count_next = count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (ctrl.execute)
            count_reg <= count_next;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            cmd_reg   <= fqd_pkg::cmd_t'(cmd);
            value_reg <= value;
        end
        if (ctrl.execute)
        begin
            entries_reg <= entries_next;
            status_reg  <= status_next;
            data_reg    <= data_next;
            length_reg  <= fqd_pkg::LEN_W'(count_next);
        end
    end

    assign status   = status_reg;
    assign data_out = data_reg;
    assign length   = length_reg;

endmodule

@@ rtl/core/fifo_queue_with_delete.sv @@
// ============================================================================
// fifo_queue_with_delete : bounded queue of nonzero 32-bit handles
// Enqueue, dequeue, delete-first-match and length query, one result each.
// ============================================================================
// Each command is captured from the transfer, then executed: the entry
// chain compares every slot against the value and compacts in parallel.
// A result waits in its own register, so the next command is captured
// while it is pending; execution holds only while the previous result
// has not been taken. A zero value on enqueue or delete, enqueue when
// full, dequeue when empty and an unmatched delete return status 1 and
// leave the queue unchanged. The queue starts empty after reset.
module fifo_queue_with_delete (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  logic [1:0]                 cmd,
    input  logic [fqd_pkg::DATA_W-1:0] value,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output logic                       status,
    output logic [fqd_pkg::DATA_W-1:0] data_out,
    output logic [fqd_pkg::LEN_W-1:0]  length
);

    fqd_pkg::ctrl_t ctrl;

    fqd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .ctrl      (ctrl)
    );

    fqd_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .cmd      (cmd),
        .value    (value),
        .status   (status),
        .data_out (data_out),
        .length   (length)
    );

endmodule

@@ rtl/core/fqd_checker.sv @@
// ============================================================================
// fqd_checker : port-level checks for the handle queue
// Watches the top-level ports and flags result and sequencing slips.
// ============================================================================
module fqd_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       cmd_valid,
    input logic                       cmd_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic                       status,
    input logic [fqd_pkg::DATA_W-1:0] data_out,
    input logic [fqd_pkg::LEN_W-1:0]  length
);

    a_data_only_on_success: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (data_out != '0) |-> !status)
        else $error("data_out nonzero on an error result");

    a_length_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(length) <= fqd_pkg::DEPTH))
        else $error("reported length exceeds depth");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("second command captured before execution");

    a_rsp_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!cmd_ready))
        else $error("result appeared without an executing command");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(data_out) && $stable(status))
        else $error("pending result dropped or changed");

endmodule

bind fifo_queue_with_delete fqd_checker u_fqd_checker (.*);

@@ tb/sv/tb_fifo_queue_with_delete.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_fifo_queue_with_delete : self-checking bench for the handle queue
// Drives enqueue, dequeue, delete-first-match and length commands through
// the valid/ready command port, mirrors the queue in a local model and
// compares every response transfer field by field in order. Directed cases
// cover empty, full, zero-handle and duplicate-delete behavior; random
// fill/drain rounds and a biased command mix follow, with random idle
// cycles on both ports and one stretch at full rate.
// ============================================================================
module tb_fifo_queue_with_delete;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic                       status;
        logic [fqd_pkg::DATA_W-1:0] data_out;
        logic [fqd_pkg::LEN_W-1:0]  length;
    } queue_result_t;

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cmd_valid = 1'b0;
    logic                       cmd_ready;
    logic [1:0]                 cmd       = fqd_pkg::CMD_LEN;
    logic [fqd_pkg::DATA_W-1:0] value     = '0;
    logic                       rsp_valid;
    logic                       rsp_ready = 1'b0;
    logic                       status;
    logic [fqd_pkg::DATA_W-1:0] data_out;
    logic [fqd_pkg::LEN_W-1:0]  length;

    logic [fqd_pkg::DATA_W-1:0] model_entries[$];
    queue_result_t              awaited_results[$];
    int                         send_idle_pct = 6;
    int                         rsp_stall_pct = 6;
    int                         mismatches    = 0;
    int                         cycle_count   = 0;

    fifo_queue_with_delete dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .status    (status),
        .data_out  (data_out),
        .length    (length)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Queue model: applies one accepted command, records the expected response
    function automatic void predict_queue_cmd(input fqd_pkg::cmd_t c,
                                              input logic [fqd_pkg::DATA_W-1:0] v);
        queue_result_t res;
        int            hit;
        res  = '0;
        hit  = -1;
        case (c)
            fqd_pkg::CMD_ENQ:
            begin
                if (v == '0 || model_entries.size() >= fqd_pkg::DEPTH)
                    res.status = 1'b1;
                else
                    model_entries.push_back(v);
            end
            fqd_pkg::CMD_DEQ:
            begin
                if (model_entries.size() == 0)
                    res.status = 1'b1;
                else
                    res.data_out = model_entries.pop_front();
            end
            fqd_pkg::CMD_DEL:
            begin
                if (v != '0)
                begin
                    for (int i = 0; i < model_entries.size(); i++)
                    begin
                        if (hit < 0 && model_entries[i] == v)
                            hit = i;
                    end
                end
                if (hit < 0)
                    res.status = 1'b1;
                else
                    model_entries.delete(hit);
            end
            default: ;
        endcase
        res.length = fqd_pkg::LEN_W'(model_entries.size());
        awaited_results.push_back(res);
    endfunction

    // Called at a rising edge; returns at the edge where the transfer happens
    task automatic send_cmd(input fqd_pkg::cmd_t c, input logic [fqd_pkg::DATA_W-1:0] v);
        int gap;
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 4);
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        value     <= v;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
        predict_queue_cmd(c, v);
    endtask

    // Small pool gives duplicates and delete hits; full range toggles every bit
    function automatic logic [fqd_pkg::DATA_W-1:0] pick_handle(input int zero_pct);
        int r;
        r = $urandom_range(99);
        if (r < zero_pct)
            return '0;
        else if (r < 55)
            return fqd_pkg::DATA_W'($urandom_range(1, 12));
        else
            return $urandom();
    endfunction

    function automatic logic [fqd_pkg::DATA_W-1:0] pick_stored_handle();
        if (model_entries.size() == 0)
            return pick_handle(0);
        return model_entries[$urandom_range(model_entries.size() - 1)];
    endfunction

    always @(posedge clk)
    begin
        queue_result_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("response transfer with no command outstanding");
                mismatches++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
                if (data_out !== want.data_out)
                begin
                    $error("data_out: expected %h, got %h", want.data_out, data_out);
                    mismatches++;
                end
                if (length !== want.length)
                begin
                    $error("length: expected %0d, got %0d", want.length, length);
                    mismatches++;
                end
            end
        end
        rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
    end

    task automatic test_empty_queue();
        send_cmd(fqd_pkg::CMD_LEN, 32'h0000_0000);
        send_cmd(fqd_pkg::CMD_DEQ, 32'h0000_0000);
        send_cmd(fqd_pkg::CMD_DEL, 32'h0000_0005);
        send_cmd(fqd_pkg::CMD_ENQ, 32'h0000_0000);
    endtask

    task automatic test_extreme_handles();
        send_cmd(fqd_pkg::CMD_ENQ, 32'hFFFF_FFFF);
        send_cmd(fqd_pkg::CMD_ENQ, 32'h0000_0001);
        send_cmd(fqd_pkg::CMD_ENQ, 32'h8000_0000);
        send_cmd(fqd_pkg::CMD_LEN, 32'hFFFF_FFFF);
        send_cmd(fqd_pkg::CMD_DEQ, 32'hA5A5_A5A5);
        send_cmd(fqd_pkg::CMD_DEQ, 32'h0000_0000);
        send_cmd(fqd_pkg::CMD_DEQ, 32'hFFFF_FFFF);
    endtask

    task automatic test_delete_first_match();
        send_cmd(fqd_pkg::CMD_ENQ, 32'h0000_0007);
        send_cmd(fqd_pkg::CMD_ENQ, 32'h0000_0009);
        send_cmd(fqd_pkg::CMD_ENQ, 32'h0000_0007);
        send_cmd(fqd_pkg::CMD_DEL, 32'h0000_0000);
        send_cmd(fqd_pkg::CMD_DEL, 32'h0000_0003);
        send_cmd(fqd_pkg::CMD_DEL, 32'h0000_0007);
        send_cmd(fqd_pkg::CMD_DEQ, 32'h0000_0000);
        send_cmd(fqd_pkg::CMD_DEQ, 32'h0000_0000);
    endtask

    // Fill past full, delete stored and absent handles, then drain past empty
    task automatic test_fill_and_drain(input int rounds);
        for (int r = 0; r < rounds; r++)
        begin
            for (int i = 0; i < fqd_pkg::DEPTH + 2; i++)
                send_cmd(fqd_pkg::CMD_ENQ, pick_handle(3));
            send_cmd(fqd_pkg::CMD_LEN, $urandom());
            send_cmd(fqd_pkg::CMD_DEL, $urandom() | 32'h0001_0000);
            repeat (3)
                send_cmd(fqd_pkg::CMD_DEL, pick_stored_handle());
            while (model_entries.size() != 0)
                send_cmd(fqd_pkg::CMD_DEQ, $urandom());
            send_cmd(fqd_pkg::CMD_DEQ, $urandom());
            send_cmd(fqd_pkg::CMD_DEL, pick_handle(10));
        end
    endtask

    task automatic test_random_mix(input int blocks);
        int enq_weight;
        int r;
        for (int b = 0; b < blocks; b++)
        begin
            case ($urandom_range(2))
                0:       enq_weight = 70;
                1:       enq_weight = 45;
                default: enq_weight = 25;
            endcase
            // one long stretch at full rate on both ports
            send_idle_pct = (b == 4 || b == 5) ? 0 : 6;
            rsp_stall_pct = (b == 4 || b == 5) ? 0 : 6;
            for (int i = 0; i < 100; i++)
            begin
                r = $urandom_range(99);
                if (r < enq_weight)
                    send_cmd(fqd_pkg::CMD_ENQ, pick_handle(3));
                else
                begin
                    r = $urandom_range(99);
                    if (r < 35)
                        send_cmd(fqd_pkg::CMD_DEQ, $urandom());
                    else if (r < 80)
                        send_cmd(fqd_pkg::CMD_DEL,
                                 ($urandom_range(99) < 70) ? pick_stored_handle()
                                                           : pick_handle(8));
                    else
                        send_cmd(fqd_pkg::CMD_LEN, $urandom());
                end
            end
        end
        send_idle_pct = 6;
        rsp_stall_pct = 6;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_extreme_handles();
        test_delete_first_match();
        test_fill_and_drain(5);
        test_random_mix(10);

        cmd_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/fqd_pkg.sv
rtl/core/fqd_ctrl.sv
rtl/core/fqd_datapath.sv
rtl/core/fifo_queue_with_delete.sv
rtl/core/fqd_checker.sv
tb/sv/tb_fifo_queue_with_delete.sv
